[src/adsr_pkg.sv]
package adsr_pkg;

  // Field widths
  localparam int unsigned SMP_W  = 16;              // sample width
  localparam int unsigned LEN_W  = 20;              // segment length / offset width
  localparam int unsigned LVL_W  = 16;              // gain level width, Q1.15
  localparam int unsigned FRAC_W = 15;              // gain fraction bits
  localparam int unsigned CFG_W  = 20;              // widest register
  localparam int unsigned IDX_W  = 3;               // register index width

  // Derived widths
  localparam int unsigned PROD_W = LVL_W + LEN_W;   // level delta times offset
  localparam int unsigned SCL_W  = SMP_W + LVL_W;   // sample magnitude times gain
  localparam int unsigned MAG_W  = SCL_W - FRAC_W;  // scaled magnitude
  localparam int unsigned CNT_W  = $clog2(LVL_W);   // divider step counter

  // Register reset values
  localparam logic [LVL_W-1:0] LVL_INITIAL_RST = LVL_W'(0);
  localparam logic [LVL_W-1:0] LVL_ATTACK_RST  = LVL_W'(1 << FRAC_W);
  localparam logic [LVL_W-1:0] LVL_SUSTAIN_RST = LVL_W'(1 << FRAC_W);
  localparam logic [LVL_W-1:0] LVL_RELEASE_RST = LVL_W'(0);

  typedef enum logic [IDX_W-1:0] {
    REG_INITIAL_LEVEL   = 3'd0,
    REG_ATTACK_LEVEL    = 3'd1,
    REG_SUSTAIN_LEVEL   = 3'd2,
    REG_RELEASE_LEVEL   = 3'd3,
    REG_ATTACK_SAMPLES  = 3'd4,
    REG_DECAY_SAMPLES   = 3'd5,
    REG_RELEASE_SAMPLES = 3'd6
  } cfg_reg_e;

  typedef enum logic [1:0] {
    SEG_ATTACK  = 2'd0,
    SEG_DECAY   = 2'd1,
    SEG_SUSTAIN = 2'd2,
    SEG_RELEASE = 2'd3
  } seg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_NORM_PRE,
    ST_MUL,
    ST_DIV,
    ST_SCALE,
    ST_ADVANCE,
    ST_NORM_POST,
    ST_OUT_ENV,
    ST_OUT_PASS
  } ctrl_state_e;

  // Controller to datapath
  typedef struct packed {
    logic load_in;    // capture input transaction, start note if flagged
    logic norm_step;  // skip one finished/empty segment
    logic ramp_mul;   // level delta times offset, seed divider
    logic div_step;   // one restoring division step
    logic scale;      // sample magnitude times gain
    logic advance;    // bump segment offset
    logic out_env;    // load enveloped result
    logic out_pass;   // load pass-through result
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic skip;       // active and offset not below segment length
    logic active;
    logic sustain;    // current segment is sustain (flat gain)
    logic out_free;   // output register can take a result
  } status_t;

endpackage

[src/adsr_stream_if.sv]
interface adsr_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [adsr_pkg::SMP_W-1:0]   sample_in;
  logic                                note_start;
  logic        [adsr_pkg::LEN_W-1:0]   hold_samples;

  modport source (output valid, sample_in, note_start, hold_samples, input ready);
  modport sink   (input valid, sample_in, note_start, hold_samples, output ready);
endinterface

interface adsr_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [adsr_pkg::SMP_W-1:0]   sample_out;
  logic                                in_note;
  logic                                note_end;

  modport source (output valid, sample_out, in_note, note_end, input ready);
  modport sink   (input valid, sample_out, in_note, note_end, output ready);
endinterface

[src/adsr_linear_envelope.sv]
// Channel   Direction  Payload                                   Handshake
// in_i      sink       sample_in[15:0] s, note_start, hold[19:0]  valid/ready
// out_o     source     sample_out[15:0] s, in_note, note_end      valid/ready
// cfg_*     input      we, idx[2:0], data[19:0]                   write on we
//
// Sequencing: one transaction at a time, from one accepted input to the next.
// A ramp sample runs the 16-step restoring divider for the gain; a sustain sample
// skips it, and a sample outside a note passes through (one more step per skipped segment).
// Reset: rst_ni async, active low; config and state registers take their documented defaults.
// Stalls: a finished result sits in the output register, so the next input
// transaction is taken while it waits; the next result waits for it to drain.

module adsr_linear_envelope (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [adsr_pkg::IDX_W-1:0]  cfg_idx_i,
  input  logic [adsr_pkg::CFG_W-1:0]  cfg_data_i,
  adsr_in_if.sink                     in_i,
  adsr_out_if.source                  out_o
);

  // Command and status between sequencer and datapath
  adsr_pkg::cmd_t    cmd;
  adsr_pkg::status_t status;
  logic              in_ready;

  // Sequencer: normalise segment, multiply and divide (ramp only), scale, advance,
  // normalise again, then hand the result (or a pass-through) to the output register.
  adsr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  assign in_i.ready = in_ready;

  // Datapath: registers, note state, ramp multiplier and divider,
  // gain multiply with saturation, and the output register.
  adsr_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .sample_in_i    (in_i.sample_in),
    .note_start_i   (in_i.note_start),
    .hold_samples_i (in_i.hold_samples),
    .cmd_i          (cmd),
    .status_o       (status),
    .out_o          (out_o)
  );

endmodule

[src/adsr_dp.sv]
module adsr_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [adsr_pkg::IDX_W-1:0]          cfg_idx_i,
  input  logic [adsr_pkg::CFG_W-1:0]          cfg_data_i,
  input  logic signed [adsr_pkg::SMP_W-1:0]   sample_in_i,
  input  logic                                note_start_i,
  input  logic [adsr_pkg::LEN_W-1:0]          hold_samples_i,
  input  adsr_pkg::cmd_t                      cmd_i,
  output adsr_pkg::status_t                   status_o,
  adsr_out_if.source                          out_o
);

  localparam logic [adsr_pkg::MAG_W-1:0] MAG_POS_LIM =
    adsr_pkg::MAG_W'((1 << (adsr_pkg::SMP_W - 1)) - 1);
  localparam logic [adsr_pkg::MAG_W-1:0] MAG_NEG_LIM =
    adsr_pkg::MAG_W'(1 << (adsr_pkg::SMP_W - 1));
  localparam logic [adsr_pkg::SMP_W-1:0] SMP_MAX =
    adsr_pkg::SMP_W'((1 << (adsr_pkg::SMP_W - 1)) - 1);
  localparam logic [adsr_pkg::SMP_W-1:0] SMP_MIN =
    adsr_pkg::SMP_W'(1 << (adsr_pkg::SMP_W - 1));

  // Configuration registers
  logic [adsr_pkg::LVL_W-1:0] init_lvl_q, atk_lvl_q, sus_lvl_q, rel_lvl_q;
  logic [adsr_pkg::LEN_W-1:0] atk_len_q, dec_len_q, rel_len_q;

  // Note state
  adsr_pkg::seg_e             seg_q;
  logic [adsr_pkg::LEN_W-1:0] off_q;
  logic [adsr_pkg::LEN_W-1:0] held_q;
  logic                       active_q;

  // Working registers
  logic [adsr_pkg::SMP_W-1:0] sample_q;
  logic [adsr_pkg::LEN_W-1:0] rem_q;
  logic [adsr_pkg::LVL_W-1:0] quo_q;
  logic [adsr_pkg::SCL_W-1:0] prod_q;

  // Output register
  logic                       out_valid_q;
  logic [adsr_pkg::SMP_W-1:0] out_smp_q;
  logic                       out_in_note_q;
  logic                       out_end_q;

  logic [adsr_pkg::LEN_W-1:0]  seg_len;
  logic [adsr_pkg::LVL_W-1:0]  y1, y2, diff, gain;
  logic                        up;
  logic [adsr_pkg::PROD_W-1:0] ramp_prod;
  logic [adsr_pkg::LEN_W:0]    div_trial;
  logic                        div_ge;
  logic [adsr_pkg::SMP_W-1:0]  abs_smp;
  logic                        neg;
  logic [adsr_pkg::MAG_W-1:0]  mag_sh;
  logic [adsr_pkg::SMP_W-1:0]  sat_smp;
  logic                        out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_lvl_q <= adsr_pkg::LVL_INITIAL_RST;
      atk_lvl_q  <= adsr_pkg::LVL_ATTACK_RST;
      sus_lvl_q  <= adsr_pkg::LVL_SUSTAIN_RST;
      rel_lvl_q  <= adsr_pkg::LVL_RELEASE_RST;
      atk_len_q  <= '0;
      dec_len_q  <= '0;
      rel_len_q  <= '0;
    end else if (cfg_we_i) begin
      case (adsr_pkg::cfg_reg_e'(cfg_idx_i))
        adsr_pkg::REG_INITIAL_LEVEL:   init_lvl_q <= cfg_data_i[adsr_pkg::LVL_W-1:0];
        adsr_pkg::REG_ATTACK_LEVEL:    atk_lvl_q  <= cfg_data_i[adsr_pkg::LVL_W-1:0];
        adsr_pkg::REG_SUSTAIN_LEVEL:   sus_lvl_q  <= cfg_data_i[adsr_pkg::LVL_W-1:0];
        adsr_pkg::REG_RELEASE_LEVEL:   rel_lvl_q  <= cfg_data_i[adsr_pkg::LVL_W-1:0];
        adsr_pkg::REG_ATTACK_SAMPLES:  atk_len_q  <= cfg_data_i[adsr_pkg::LEN_W-1:0];
        adsr_pkg::REG_DECAY_SAMPLES:   dec_len_q  <= cfg_data_i[adsr_pkg::LEN_W-1:0];
        adsr_pkg::REG_RELEASE_SAMPLES: rel_len_q  <= cfg_data_i[adsr_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Segment length and ramp end points
  always_comb begin
    case (seg_q)
      adsr_pkg::SEG_ATTACK: begin
        seg_len = atk_len_q;
        y1      = init_lvl_q;
        y2      = atk_lvl_q;
      end
      adsr_pkg::SEG_DECAY: begin
        seg_len = dec_len_q;
        y1      = atk_lvl_q;
        y2      = sus_lvl_q;
      end
      adsr_pkg::SEG_SUSTAIN: begin
        seg_len = held_q;
        y1      = sus_lvl_q;
        y2      = sus_lvl_q;
      end
      default: begin
        seg_len = rel_len_q;
        y1      = sus_lvl_q;
        y2      = rel_lvl_q;
      end
    endcase
  end

  assign up        = (y2 >= y1);
  assign diff      = up ? (y2 - y1) : (y1 - y2);
  assign ramp_prod = adsr_pkg::PROD_W'(diff) * adsr_pkg::PROD_W'(off_q);

  // Quotient is below 2^LVL_W (offset < length), so the top bits seed the remainder
  assign div_trial = {rem_q, quo_q[adsr_pkg::LVL_W-1]};
  assign div_ge    = (div_trial >= {1'b0, seg_len});

  always_comb begin
    if (seg_q == adsr_pkg::SEG_SUSTAIN) begin
      gain = sus_lvl_q;
    end else if (up) begin
      gain = y1 + quo_q;
    end else begin
      gain = y1 - quo_q;
    end
  end

  assign neg     = sample_q[adsr_pkg::SMP_W-1];
  assign abs_smp = neg ? (~sample_q + adsr_pkg::SMP_W'(1)) : sample_q;

  // Truncate toward zero on the magnitude, then saturate
  assign mag_sh = prod_q[adsr_pkg::SCL_W-1:adsr_pkg::FRAC_W];
  always_comb begin
    if (!neg) begin
      sat_smp = (mag_sh > MAG_POS_LIM) ? SMP_MAX : mag_sh[adsr_pkg::SMP_W-1:0];
    end else begin
      sat_smp = (mag_sh > MAG_NEG_LIM) ? SMP_MIN
                                       : (~mag_sh[adsr_pkg::SMP_W-1:0] + adsr_pkg::SMP_W'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_q    <= adsr_pkg::SEG_ATTACK;
      off_q    <= '0;
      held_q   <= '0;
      active_q <= 1'b0;
    end else if (cmd_i.load_in) begin
      if (note_start_i) begin
        active_q <= 1'b1;
        seg_q    <= adsr_pkg::SEG_ATTACK;
        off_q    <= '0;
        held_q   <= hold_samples_i;
      end
    end else if (cmd_i.norm_step && status_o.skip) begin
      off_q <= '0;
      if (seg_q == adsr_pkg::SEG_RELEASE) begin
        active_q <= 1'b0;
        seg_q    <= adsr_pkg::SEG_ATTACK;
      end else begin
        seg_q <= adsr_pkg::seg_e'(seg_q + 2'd1);
      end
    end else if (cmd_i.advance) begin
      off_q <= off_q + adsr_pkg::LEN_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      sample_q <= sample_in_i;
    end
    if (cmd_i.ramp_mul) begin
      rem_q <= ramp_prod[adsr_pkg::PROD_W-1:adsr_pkg::LVL_W];
      quo_q <= ramp_prod[adsr_pkg::LVL_W-1:0];
    end else if (cmd_i.div_step) begin
      rem_q <= div_ge ? adsr_pkg::LEN_W'(div_trial - {1'b0, seg_len})
                      : div_trial[adsr_pkg::LEN_W-1:0];
      quo_q <= {quo_q[adsr_pkg::LVL_W-2:0], div_ge};
    end
    if (cmd_i.scale) begin
      prod_q <= adsr_pkg::SCL_W'(abs_smp) * adsr_pkg::SCL_W'(gain);
    end
  end

  assign out_free = !out_valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_env || cmd_i.out_pass) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_env) begin
      out_smp_q     <= sat_smp;
      out_in_note_q <= 1'b1;
      out_end_q     <= !active_q;
    end else if (cmd_i.out_pass) begin
      out_smp_q     <= sample_q;
      out_in_note_q <= 1'b0;
      out_end_q     <= 1'b0;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.sample_out = out_smp_q;
  assign out_o.in_note    = out_in_note_q;
  assign out_o.note_end   = out_end_q;

  assign status_o.skip     = active_q && (off_q >= seg_len);
  assign status_o.active   = active_q;
  assign status_o.sustain  = (seg_q == adsr_pkg::SEG_SUSTAIN);
  assign status_o.out_free = out_free;

endmodule

[src/adsr_ctrl.sv]
module adsr_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  adsr_pkg::status_t  status_i,
  output adsr_pkg::cmd_t     cmd_o
);

  localparam logic [adsr_pkg::CNT_W-1:0] CNT_LAST = adsr_pkg::CNT_W'(adsr_pkg::LVL_W - 1);

  adsr_pkg::ctrl_state_e     state_q, state_d;
  logic [adsr_pkg::CNT_W-1:0] cnt_q, cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= adsr_pkg::ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      adsr_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = adsr_pkg::ST_NORM_PRE;
        end
      end
      adsr_pkg::ST_NORM_PRE: begin
        if (status_i.skip) begin
          cmd_o.norm_step = 1'b1;
        end else if (!status_i.active) begin
          state_d = adsr_pkg::ST_OUT_PASS;
        end else if (status_i.sustain) begin
          state_d = adsr_pkg::ST_SCALE;
        end else begin
          state_d = adsr_pkg::ST_MUL;
        end
      end
      adsr_pkg::ST_MUL: begin
        cmd_o.ramp_mul = 1'b1;
        cnt_d          = '0;
        state_d        = adsr_pkg::ST_DIV;
      end
      adsr_pkg::ST_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + adsr_pkg::CNT_W'(1);
        if (cnt_q == CNT_LAST) begin
          state_d = adsr_pkg::ST_SCALE;
        end
      end
      adsr_pkg::ST_SCALE: begin
        cmd_o.scale = 1'b1;
        state_d     = adsr_pkg::ST_ADVANCE;
      end
      adsr_pkg::ST_ADVANCE: begin
        cmd_o.advance = 1'b1;
        state_d       = adsr_pkg::ST_NORM_POST;
      end
      adsr_pkg::ST_NORM_POST: begin
        if (status_i.skip) begin
          cmd_o.norm_step = 1'b1;
        end else begin
          state_d = adsr_pkg::ST_OUT_ENV;
        end
      end
      adsr_pkg::ST_OUT_ENV: begin
        if (status_i.out_free) begin
          cmd_o.out_env = 1'b1;
          state_d       = adsr_pkg::ST_IDLE;
        end
      end
      adsr_pkg::ST_OUT_PASS: begin
        if (status_i.out_free) begin
          cmd_o.out_pass = 1'b1;
          state_d        = adsr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = adsr_pkg::ST_IDLE;
      end
    endcase
  end

endmodule
